FILE: src/lrcf_pkg.sv
// Package for the line rasterizer with corner fill.
// Holds the coordinate widths, the stream packing widths, the queue command type
// and the coordinate step helper. It depends on nothing else.
package lrcf_pkg;

  localparam int COORD_W    = 10;
  localparam int ERR_W      = COORD_W + 3;
  localparam int IN_DATA_W  = ((4 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * COORD_W + 7) / 8) * 8;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_CORNER = 1'b0,
    KIND_LINE   = 1'b1
  } pixel_kind_t;

  // One classified request, as queued between front and back.
  typedef struct packed {
    req_type_t req;
    logic      x_neg;
    logic      y_neg;
    logic      x_major;
    coord_t    dmaj;
    coord_t    dmin;
    coord_t    sx;
    coord_t    sy;
  } lrcf_cmd_t;

  // Move one unit along an axis, wrapping at the coordinate width.
  function automatic coord_t step_coord(input coord_t v, input logic neg);
    coord_t res;
    res = neg ? (v - coord_t'(1)) : (v + coord_t'(1));
    return res;
  endfunction

endpackage

FILE: src/line_rasterizer_with_corner_fill_unit.sv
// Top level of the Bresenham line rasterizer with corner fill.
// Instantiates lrcf_front, lrcf_queue and lrcf_back; depends on lrcf_pkg.
//
// Usage:
//   Input channel (in_*): one transaction per request. in_tuser is the request
//   type: start a new line (endpoints in in_tdata) or advance one major step.
//   Output channel (out_*): one transaction per pixel. A start yields its first
//   line pixel; a step on an active line yields a corner fill pixel and then
//   the new line pixel, the latter with out_tlast high. A step with no line in
//   progress yields nothing. A start while a line runs abandons that line.
// Path: an accepted request is written into a queue slot and, when the queue
//   held nothing ahead of it and the output is free, its first pixel is loaded
//   from there into the output register.
// Throughput: the back part takes a new command only while its output
//   register is free and no line pixel is pending, so an active step holds
//   off the next command until its line pixel has gone out. The front accepts
//   one request per cycle until the four-entry command queue fills.
// Reset: rst_n low at a clock edge empties the queue, drops any pending pixel
//   and leaves the rasterizer idle with all line state at zero.
// Stall: while out_tready is low the output transaction holds; the back part
//   halts and the queue absorbs up to four more requests before in_tready
//   drops.
module line_rasterizer_with_corner_fill_unit
  import lrcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pixel_x, pixel_y, zero pad
  output logic [1:0]            out_tuser,  // pixel_kind, line_done
  output logic                  out_tlast   // last pixel of this request
);

  lrcf_cmd_t front_cmd;
  lrcf_cmd_t pop_cmd;
  logic      pop_valid;
  logic      pop_ready;

  // classify the incoming request
  lrcf_front u_front (
    .in_req  (in_tuser),
    .in_data (in_tdata),
    .cmd     (front_cmd)
  );

  // decouple the front from the back; in_tready follows queue space
  lrcf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_cmd   (front_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // run the line state and drive the output channel
  lrcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: src/lrcf_front.sv
// Front part of the line rasterizer: unpacks an input transaction and classifies it.
// Computes absolute deltas, step directions and the major axis of a start request.
// Depends on lrcf_pkg.
module lrcf_front
  import lrcf_pkg::*;
(
  input  logic                 in_req,     // request type
  input  logic [IN_DATA_W-1:0] in_data,    // start_x, start_y, end_x, end_y
  output lrcf_cmd_t            cmd
);

  coord_t sx;
  coord_t sy;
  coord_t ex;
  coord_t ey;
  coord_t dx;
  coord_t dy;
  logic   x_neg;
  logic   y_neg;
  logic   x_major;

  assign sx = in_data[COORD_W-1:0];
  assign sy = in_data[2*COORD_W-1:COORD_W];
  assign ex = in_data[3*COORD_W-1:2*COORD_W];
  assign ey = in_data[4*COORD_W-1:3*COORD_W];

  assign x_neg   = ex < sx;
  assign y_neg   = ey < sy;
  assign dx      = x_neg ? (sx - ex) : (ex - sx);
  assign dy      = y_neg ? (sy - ey) : (ey - sy);
  // ties go to y
  assign x_major = dx > dy;

  always_comb begin
    cmd.req     = req_type_t'(in_req);
    cmd.x_neg   = x_neg;
    cmd.y_neg   = y_neg;
    cmd.x_major = x_major;
    cmd.dmaj    = x_major ? dx : dy;
    cmd.dmin    = x_major ? dy : dx;
    cmd.sx      = sx;
    cmd.sy      = sy;
  end

endmodule

FILE: src/lrcf_queue.sv
// Short command queue between the front and back parts of the rasterizer.
// Holds QDEPTH classified commands in registers with read and write pointers.
// Depends on lrcf_pkg.
module lrcf_queue
  import lrcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  lrcf_cmd_t push_cmd,
  output logic      pop_valid,
  input  logic      pop_ready,
  output lrcf_cmd_t pop_cmd
);

  lrcf_cmd_t          slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r;
  logic [QCNT_W-1:0]  count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count_r != QCNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: src/lrcf_back.sv
// Back part of the rasterizer: holds the Bresenham state and emits pixels.
// Pops classified commands from the queue and drives the output register.
// Depends on lrcf_pkg.
module lrcf_back
  import lrcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  lrcf_cmd_t             pop_cmd,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  // line state
  coord_t              cur_x_r, cur_x_nxt;
  coord_t              cur_y_r, cur_y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic signed [ERR_W-1:0] diag_incr_r, diag_incr_nxt;
  logic signed [ERR_W-1:0] straight_incr_r, straight_incr_nxt;
  logic                x_neg_r, x_neg_nxt;
  logic                y_neg_r, y_neg_nxt;
  logic                x_major_r, x_major_nxt;
  coord_t              steps_r, steps_nxt;
  logic                active_r, active_nxt;

  // output register and pending line pixel of a step
  logic                out_valid_r, out_valid_nxt;
  coord_t              out_x_r, out_x_nxt;
  coord_t              out_y_r, out_y_nxt;
  pixel_kind_t         out_kind_r, out_kind_nxt;
  logic                out_done_r, out_done_nxt;
  logic                out_last_r, out_last_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  coord_t              pend_x_r, pend_x_nxt;
  coord_t              pend_y_r, pend_y_nxt;
  logic                pend_done_r, pend_done_nxt;

  logic                out_free;
  logic                fire;
  logic                diag;
  coord_t              nx;
  coord_t              ny;
  logic signed [ERR_W-1:0] twice_min;
  logic signed [ERR_W-1:0] twice_maj;

  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = out_free && !pend_valid_r;
  assign fire      = pop_valid && pop_ready;

  assign diag = !err_r[ERR_W-1];
  assign nx   = (x_major_r || diag) ? step_coord(cur_x_r, x_neg_r) : cur_x_r;
  assign ny   = (!x_major_r || diag) ? step_coord(cur_y_r, y_neg_r) : cur_y_r;

  assign twice_min = {2'b00, pop_cmd.dmin, 1'b0};
  assign twice_maj = {2'b00, pop_cmd.dmaj, 1'b0};

  always_comb begin
    cur_x_nxt         = cur_x_r;
    cur_y_nxt         = cur_y_r;
    err_nxt           = err_r;
    diag_incr_nxt     = diag_incr_r;
    straight_incr_nxt = straight_incr_r;
    x_neg_nxt         = x_neg_r;
    y_neg_nxt         = y_neg_r;
    x_major_nxt       = x_major_r;
    steps_nxt         = steps_r;
    active_nxt        = active_r;
    out_valid_nxt     = out_valid_r;
    out_x_nxt         = out_x_r;
    out_y_nxt         = out_y_r;
    out_kind_nxt      = out_kind_r;
    out_done_nxt      = out_done_r;
    out_last_nxt      = out_last_r;
    pend_valid_nxt    = pend_valid_r;
    pend_x_nxt        = pend_x_r;
    pend_y_nxt        = pend_y_r;
    pend_done_nxt     = pend_done_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        // release the line pixel that follows a corner pixel
        out_valid_nxt  = 1'b1;
        out_x_nxt      = pend_x_r;
        out_y_nxt      = pend_y_r;
        out_kind_nxt   = KIND_LINE;
        out_done_nxt   = pend_done_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (fire) begin
        unique case (pop_cmd.req)
          REQ_START: begin
            cur_x_nxt         = pop_cmd.sx;
            cur_y_nxt         = pop_cmd.sy;
            err_nxt           = twice_min - {3'b000, pop_cmd.dmaj};
            diag_incr_nxt     = twice_min - twice_maj;
            straight_incr_nxt = twice_min;
            x_neg_nxt         = pop_cmd.x_neg;
            y_neg_nxt         = pop_cmd.y_neg;
            x_major_nxt       = pop_cmd.x_major;
            steps_nxt         = pop_cmd.dmaj;
            active_nxt        = pop_cmd.dmaj != '0;
            out_valid_nxt     = 1'b1;
            out_x_nxt         = pop_cmd.sx;
            out_y_nxt         = pop_cmd.sy;
            out_kind_nxt      = KIND_LINE;
            out_done_nxt      = pop_cmd.dmaj == '0;
            out_last_nxt      = 1'b1;
          end
          REQ_STEP: begin
            // drop a step that arrives while idle
            if (active_r) begin
              cur_x_nxt      = nx;
              cur_y_nxt      = ny;
              err_nxt        = err_r + (diag ? diag_incr_r : straight_incr_r);
              steps_nxt      = steps_r - coord_t'(1);
              active_nxt     = steps_r != coord_t'(1);
              out_valid_nxt  = 1'b1;
              // after a diagonal step x is back by one step direction
              out_x_nxt      = diag ? cur_x_r : nx;
              out_y_nxt      = ny;
              out_kind_nxt   = KIND_CORNER;
              out_done_nxt   = 1'b0;
              out_last_nxt   = 1'b0;
              pend_valid_nxt = 1'b1;
              pend_x_nxt     = nx;
              pend_y_nxt     = ny;
              pend_done_nxt  = steps_r == coord_t'(1);
            end
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r         <= '0;
      cur_y_r         <= '0;
      err_r           <= '0;
      diag_incr_r     <= '0;
      straight_incr_r <= '0;
      x_neg_r         <= 1'b0;
      y_neg_r         <= 1'b0;
      x_major_r       <= 1'b0;
      steps_r         <= '0;
      active_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      pend_valid_r    <= 1'b0;
    end else begin
      cur_x_r         <= cur_x_nxt;
      cur_y_r         <= cur_y_nxt;
      err_r           <= err_nxt;
      diag_incr_r     <= diag_incr_nxt;
      straight_incr_r <= straight_incr_nxt;
      x_neg_r         <= x_neg_nxt;
      y_neg_r         <= y_neg_nxt;
      x_major_r       <= x_major_nxt;
      steps_r         <= steps_nxt;
      active_r        <= active_nxt;
      out_valid_r     <= out_valid_nxt;
      pend_valid_r    <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_kind_r  <= out_kind_nxt;
    out_done_r  <= out_done_nxt;
    out_last_r  <= out_last_nxt;
    pend_x_r    <= pend_x_nxt;
    pend_y_r    <= pend_y_nxt;
    pend_done_r <= pend_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * COORD_W){1'b0}}, out_y_r, out_x_r};
  assign out_tuser  = {out_done_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule
